@@ rtl/klcat_pkg.sv @@
// shared types and constants for the k-line collision-aware transmitter
package klcat_pkg;

    localparam logic [2:0] ST_WAIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_BITS  = 3'd3;
    localparam logic [2:0] ST_STOP  = 3'd4;

    localparam logic [7:0] IDLE_STEPS = 8'd8;
    localparam logic [7:0] FIRST_MASK = 8'h01;
    localparam logic [7:0] LAST_STEP  = 8'd1;

    localparam logic KIND_TICK = 1'b0;
    localparam logic KIND_PUSH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] push_byte;
        logic       line_level;
        logic       line_level_after_drive;
    } in_word_t;

    typedef struct packed {
        logic drive_level;
        logic receiver_enable;
        logic tick_running;
        logic byte_done;
        logic collision_seen;
        logic push_dropped;
    } out_word_t;

endpackage

@@ rtl/klcat_ram.sv @@
// generic single-write, single-read ram with registered read data
module klcat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/kline_collision_aware_transmitter.sv @@
// top level: k-line byte transmitter with read-back collision detection
// each word is held in the input register; its result word is registered onto m_data
// one word per cycle through these registers unless a result waits on m_ready
// the queue head byte is read from the ram at head_next, with a write bypass
// reset: synchronous active-low aresetn; wait state, empty queue, line released,
// receiver disabled, ticking on, half_bit_ticks set to 1
module kline_collision_aware_transmitter #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  klcat_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output klcat_pkg::out_word_t m_data,
    input  logic                 cfg_we,
    input  logic [15:0]          cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_INDEX = AW'(QUEUE_DEPTH - 1);

    logic                 in_valid_reg;
    klcat_pkg::in_word_t  in_word_reg;
    logic                 out_valid_reg;
    klcat_pkg::out_word_t out_word_reg, out_word_next;
    logic [15:0]          half_bit_ticks_reg;

    logic [2:0]    state_reg, state_next;
    logic [7:0]    step_count_reg, step_count_next;
    logic [15:0]   tick_count_reg, tick_count_next;
    logic [7:0]    bit_mask_reg, bit_mask_next;
    logic          previous_bit_reg, previous_bit_next;
    logic [7:0]    current_byte_reg, current_byte_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic          ticking_reg, ticking_next;
    logic          drive_reg, drive_next;
    logic          rx_enable_reg, rx_enable_next;

    logic          bypass_reg;
    logic [7:0]    bypass_data_reg;
    logic [7:0]    ram_rdata;
    logic [7:0]    head_byte;
    logic          ram_we;

    logic          advance;
    logic          process;
    logic [AW-1:0] tail_inc;
    logic [AW-1:0] head_inc;
    logic [15:0]   tick_inc;
    logic [7:0]    step_inc;
    logic          data_bit;
    logic [7:0]    mask_shift;

    assign advance = !out_valid_reg || m_ready;
    assign process = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    assign tail_inc = (tail_reg == LAST_INDEX) ? '0 : tail_reg + AW'(1);
    assign head_inc = (head_reg == LAST_INDEX) ? '0 : head_reg + AW'(1);
    assign tick_inc = tick_count_reg + 16'd1;
    assign step_inc = step_count_reg + 8'd1;
    assign data_bit = |(bit_mask_reg & current_byte_reg);
    assign mask_shift = {bit_mask_reg[6:0], 1'b0};
    assign head_byte = bypass_reg ? bypass_data_reg : ram_rdata;

    always_comb begin
        state_next        = state_reg;
        step_count_next   = step_count_reg;
        tick_count_next   = tick_count_reg;
        bit_mask_next     = bit_mask_reg;
        previous_bit_next = previous_bit_reg;
        current_byte_next = current_byte_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        ticking_next      = ticking_reg;
        drive_next        = drive_reg;
        rx_enable_next    = rx_enable_reg;
        ram_we            = 1'b0;
        out_word_next     = '0;

        if (process) begin
            if (in_word_reg.kind == klcat_pkg::KIND_PUSH) begin
                if (tail_inc == head_reg) begin
                    out_word_next.push_dropped = 1'b1;
                end else begin
                    ram_we    = 1'b1;
                    tail_next = tail_inc;
                end
                ticking_next = 1'b1;
            end else if (ticking_reg) begin
                if (tick_inc == half_bit_ticks_reg) begin
                    tick_count_next = '0;
                    step_count_next = step_inc;
                    case (state_reg)
                        klcat_pkg::ST_WAIT: begin
                            drive_next     = 1'b1;
                            rx_enable_next = 1'b1;
                            if (!in_word_reg.line_level) begin
                                step_count_next = '0;
                            end else if (step_inc >= klcat_pkg::IDLE_STEPS) begin
                                state_next = klcat_pkg::ST_IDLE;
                            end
                        end
                        klcat_pkg::ST_IDLE: begin
                            step_count_next = '0;
                            if (!in_word_reg.line_level) begin
                                state_next = klcat_pkg::ST_WAIT;
                            end else if (head_reg == tail_reg) begin
                                ticking_next   = 1'b0;
                                rx_enable_next = 1'b1;
                                state_next     = klcat_pkg::ST_WAIT;
                            end else begin
                                rx_enable_next    = 1'b0;
                                current_byte_next = head_byte;
                                state_next        = klcat_pkg::ST_START;
                            end
                        end
                        klcat_pkg::ST_START: begin
                            bit_mask_next     = klcat_pkg::FIRST_MASK;
                            previous_bit_next = 1'b0;
                            drive_next        = 1'b0;
                            if (step_inc > klcat_pkg::LAST_STEP) begin
                                step_count_next = '0;
                                state_next      = klcat_pkg::ST_BITS;
                            end
                        end
                        klcat_pkg::ST_BITS: begin
                            if (in_word_reg.line_level != previous_bit_reg) begin
                                drive_next                   = 1'b1;
                                step_count_next              = '0;
                                state_next                   = klcat_pkg::ST_WAIT;
                                out_word_next.collision_seen = 1'b1;
                            end else begin
                                previous_bit_next = data_bit;
                                drive_next        = data_bit;
                                if (step_inc > klcat_pkg::LAST_STEP) begin
                                    step_count_next = '0;
                                    bit_mask_next   = mask_shift;
                                    if (mask_shift == '0) begin
                                        state_next = klcat_pkg::ST_STOP;
                                    end
                                    if (in_word_reg.line_level_after_drive != data_bit) begin
                                        drive_next                   = 1'b1;
                                        state_next                   = klcat_pkg::ST_WAIT;
                                        out_word_next.collision_seen = 1'b1;
                                    end
                                end
                            end
                        end
                        klcat_pkg::ST_STOP: begin
                            drive_next = 1'b1;
                            if (step_inc > klcat_pkg::LAST_STEP) begin
                                head_next               = head_inc;
                                state_next              = klcat_pkg::ST_IDLE;
                                out_word_next.byte_done = 1'b1;
                            end
                        end
                        default: begin
                            state_next = klcat_pkg::ST_WAIT;
                        end
                    endcase
                end else begin
                    tick_count_next = tick_inc;
                end
            end
        end

        out_word_next.drive_level     = drive_next;
        out_word_next.receiver_enable = rx_enable_next;
        out_word_next.tick_running    = ticking_next;
    end

    klcat_ram #(
        .WIDTH(8),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (in_word_reg.push_byte),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            half_bit_ticks_reg <= 16'd1;
            state_reg          <= klcat_pkg::ST_WAIT;
            step_count_reg     <= '0;
            tick_count_reg     <= '0;
            bit_mask_reg       <= '0;
            previous_bit_reg   <= 1'b0;
            current_byte_reg   <= '0;
            head_reg           <= '0;
            tail_reg           <= '0;
            ticking_reg        <= 1'b1;
            drive_reg          <= 1'b1;
            rx_enable_reg      <= 1'b0;
            bypass_reg         <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_we) begin
                half_bit_ticks_reg <= cfg_wdata;
            end
            state_reg        <= state_next;
            step_count_reg   <= step_count_next;
            tick_count_reg   <= tick_count_next;
            bit_mask_reg     <= bit_mask_next;
            previous_bit_reg <= previous_bit_next;
            current_byte_reg <= current_byte_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            ticking_reg      <= ticking_next;
            drive_reg        <= drive_next;
            rx_enable_reg    <= rx_enable_next;
            bypass_reg       <= ram_we && (tail_reg == head_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_word_reg <= s_data;
        end
        if (process) begin
            out_word_reg <= out_word_next;
        end
        bypass_data_reg <= in_word_reg.push_byte;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    // a collision always leaves the line released
    a_coll_release: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.collision_seen |-> m_data.drive_level)
        else $error("collision reported with line driven low");

    a_done_xor_coll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.byte_done && m_data.collision_seen))
        else $error("byte done and collision in the same word");

    // receiver stays off while a frame is on the line
    a_rx_off_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == klcat_pkg::ST_START || state_reg == klcat_pkg::ST_BITS ||
         state_reg == klcat_pkg::ST_STOP) |-> !rx_enable_reg)
        else $error("receiver enabled during transmit");

    a_stopped_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        !ticking_reg |-> (state_reg == klcat_pkg::ST_WAIT))
        else $error("tick stopped outside the wait state");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        process && out_word_next.push_dropped |=> (tail_reg != head_reg))
        else $error("push dropped with queue not full");

endmodule

@@ tb/sv/tb_kline_collision_aware_transmitter.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the k-line transmitter: shaped line levels, random handshakes
module tb_kline_collision_aware_transmitter;

    localparam int DEPTH = 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 300000;

    typedef struct packed {
        logic [15:0]           half_bit;
        logic [2:0]            line_st;
        logic [7:0]            steps;
        logic [15:0]           ticks;
        logic [7:0]            mask;
        logic                  prev_bit;
        logic [7:0]            cur_byte;
        logic [DEPTH-1:0][7:0] fifo;
        logic [AW-1:0]         head;
        logic [AW-1:0]         tail;
        logic                  running;
        logic                  drive;
        logic                  rx_en;
    } kline_tx_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    klcat_pkg::in_word_t  s_data = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    klcat_pkg::out_word_t m_data;
    logic                 cfg_we = 1'b0;
    logic [15:0]          cfg_wdata = '0;

    kline_tx_t tx_shadow;
    kline_tx_t tx_track;
    klcat_pkg::in_word_t  stim_words[$];
    klcat_pkg::out_word_t want_results[$];

    string field_name[6] = '{"push_dropped", "collision_seen", "byte_done",
                             "tick_running", "receiver_enable", "drive_level"};

    bit in_taken = 1'b0;
    bit out_taken = 1'b0;
    bit in_steady = 1'b0;
    bit out_steady = 1'b0;
    int in_gap = 0;
    int out_stall = 0;
    int errors = 0;
    int cycle_count = 0;
    int words_in = 0;
    int bytes_done = 0;
    int collisions = 0;
    int drops = 0;
    int settings = 0;

    kline_collision_aware_transmitter #(
        .QUEUE_DEPTH(DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic kline_tx_t kline_reset();
        kline_tx_t m;
        m = '0;
        m.half_bit = 16'd1;
        m.line_st = klcat_pkg::ST_WAIT;
        m.running = 1'b1;
        m.drive = 1'b1;
        return m;
    endfunction

    function automatic void kline_advance(inout kline_tx_t m,
                                          input klcat_pkg::in_word_t w,
                                          output klcat_pkg::out_word_t r);
        logic [AW-1:0] nt;
        logic done;
        logic coll;
        logic drop;
        done = 1'b0;
        coll = 1'b0;
        drop = 1'b0;
        if (w.kind == klcat_pkg::KIND_PUSH) begin
            nt = AW'((int'(m.tail) + 1) % DEPTH);
            if (nt == m.head) begin
                drop = 1'b1;
            end else begin
                m.fifo[m.tail] = w.push_byte;
                m.tail = nt;
            end
            m.running = 1'b1;
        end else if (m.running) begin
            m.ticks = m.ticks + 16'd1;
            if (m.ticks == m.half_bit) begin
                m.steps = m.steps + 8'd1;
                case (m.line_st)
                    klcat_pkg::ST_WAIT: begin
                        m.drive = 1'b1;
                        m.rx_en = 1'b1;
                        if (!w.line_level) m.steps = '0;
                        if (m.steps >= klcat_pkg::IDLE_STEPS) m.line_st = klcat_pkg::ST_IDLE;
                    end
                    klcat_pkg::ST_IDLE: begin
                        m.steps = '0;
                        if (!w.line_level) begin
                            m.line_st = klcat_pkg::ST_WAIT;
                        end else if (m.head == m.tail) begin
                            m.running = 1'b0;
                            m.rx_en = 1'b1;
                            m.line_st = klcat_pkg::ST_WAIT;
                        end else begin
                            m.rx_en = 1'b0;
                            m.cur_byte = m.fifo[m.head];
                            m.line_st = klcat_pkg::ST_START;
                        end
                    end
                    klcat_pkg::ST_START: begin
                        m.mask = klcat_pkg::FIRST_MASK;
                        m.prev_bit = 1'b0;
                        m.drive = 1'b0;
                        if (m.steps > klcat_pkg::LAST_STEP) begin
                            m.steps = '0;
                            m.line_st = klcat_pkg::ST_BITS;
                        end
                    end
                    klcat_pkg::ST_BITS: begin
                        if (w.line_level != m.prev_bit) begin
                            m.drive = 1'b1;
                            m.steps = '0;
                            m.line_st = klcat_pkg::ST_WAIT;
                            coll = 1'b1;
                        end else begin
                            m.prev_bit = |(m.mask & m.cur_byte);
                            m.drive = m.prev_bit;
                            if (m.steps > klcat_pkg::LAST_STEP) begin
                                m.steps = '0;
                                m.mask = m.mask << 1;
                                if (m.mask == '0) m.line_st = klcat_pkg::ST_STOP;
                                if (w.line_level_after_drive != m.prev_bit) begin
                                    m.drive = 1'b1;
                                    m.line_st = klcat_pkg::ST_WAIT;
                                    coll = 1'b1;
                                end
                            end
                        end
                    end
                    klcat_pkg::ST_STOP: begin
                        m.drive = 1'b1;
                        if (m.steps > klcat_pkg::LAST_STEP) begin
                            m.head = AW'((int'(m.head) + 1) % DEPTH);
                            m.line_st = klcat_pkg::ST_IDLE;
                            done = 1'b1;
                        end
                    end
                    default: m.line_st = klcat_pkg::ST_WAIT;
                endcase
                m.ticks = '0;
            end
        end
        r.drive_level = m.drive;
        r.receiver_enable = m.rx_en;
        r.tick_running = m.running;
        r.byte_done = done;
        r.collision_seen = coll;
        r.push_dropped = drop;
    endfunction

    // source side
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                s_valid <= 1'b0;
            end else if (stim_words.size() > 0) begin
                s_data <= stim_words.pop_front();
                s_valid <= 1'b1;
                if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
                in_gap = in_steady ? 0 : $urandom_range(0, 4);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // sink side
    always @(negedge aclk) begin
        if (out_taken) begin
            if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
            out_stall = out_steady ? 0 : $urandom_range(0, 4);
        end
        if (out_stall > 0) begin
            out_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        klcat_pkg::out_word_t want;
        klcat_pkg::out_word_t next_want;
        in_taken = 1'b0;
        out_taken = 1'b0;
        cycle_count++;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                out_taken = 1'b1;
                if (want_results.size() == 0) begin
                    errors++;
                    if (errors <= 40)
                        $display("%0t: expected no word, got %b", $time, m_data);
                end else begin
                    want = want_results.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (want[i] !== m_data[i]) begin
                            errors++;
                            if (errors <= 40)
                                $display("%0t: %s expected %b got %b", $time,
                                         field_name[i], want[i], m_data[i]);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                in_taken = 1'b1;
                kline_advance(tx_track, s_data, next_want);
                want_results.push_back(next_want);
                words_in++;
                bytes_done += next_want.byte_done;
                collisions += next_want.collision_seen;
                drops += next_want.push_dropped;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    task automatic add_word(input klcat_pkg::in_word_t w);
        klcat_pkg::out_word_t r;
        kline_advance(tx_shadow, w, r);
        stim_words.push_back(w);
    endtask

    // clean levels follow the driven line, noise flips them now and then
    task automatic add_tick(input int noise);
        klcat_pkg::in_word_t w;
        logic stepping;
        w.kind = klcat_pkg::KIND_TICK;
        w.push_byte = 8'($urandom);
        w.line_level = 1'($urandom);
        w.line_level_after_drive = 1'($urandom);
        stepping = tx_shadow.running && (16'(tx_shadow.ticks + 16'd1) == tx_shadow.half_bit);
        if (stepping) begin
            w.line_level = tx_shadow.drive;
            if (tx_shadow.line_st == klcat_pkg::ST_BITS)
                w.line_level_after_drive = |(tx_shadow.mask & tx_shadow.cur_byte);
            if ($urandom_range(0, 99) < noise) w.line_level = ~w.line_level;
            if ($urandom_range(0, 99) < noise)
                w.line_level_after_drive = ~w.line_level_after_drive;
        end
        add_word(w);
    endtask

    task automatic add_push(input logic [7:0] b);
        klcat_pkg::in_word_t w;
        w.kind = klcat_pkg::KIND_PUSH;
        w.push_byte = b;
        w.line_level = 1'($urandom);
        w.line_level_after_drive = 1'($urandom);
        add_word(w);
    endtask

    task automatic wait_drained();
        while (stim_words.size() != 0 || s_valid || want_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_half_bit(input logic [15:0] v);
        @(negedge aclk);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        tx_shadow.half_bit = v;
        tx_track.half_bit = v;
        settings++;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int phase_bits[5];
        int phase_len[5];
        int push_pct;
        int noise;
        phase_bits = '{1, 2, 3, 5, 65535};
        phase_len = '{700, 350, 250, 150, 40};
        tx_shadow = kline_reset();
        tx_track = kline_reset();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        set_half_bit(16'd1);

        // line idle long enough, empty queue stops the tick, then fill past full
        repeat (11) add_tick(0);
        add_push(8'h00);
        add_push(8'hFF);
        add_push(8'h55);
        add_push(8'hAA);
        repeat (12) add_push(8'($urandom));
        wait_drained();

        // half-bit period only grows so the tick counter never has to wrap
        for (int p = 0; p < 5; p++) begin
            if (p > 0) set_half_bit(16'(phase_bits[p]));
            for (int n = 0; n < phase_len[p]; n += 50) begin
                push_pct = $urandom_range(1, 30);
                noise = ($urandom_range(0, 9) == 0) ? 50 : $urandom_range(0, 3);
                repeat (50) begin
                    if ($urandom_range(0, 99) < push_pct) add_push(8'($urandom));
                    else add_tick(noise);
                end
                if ($urandom_range(0, 7) == 0) wait_drained();
            end
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        $display("ran %0d words over %0d half-bit settings", words_in, settings);
        $display("%0d bytes sent, %0d collisions, %0d pushes dropped",
                 bytes_done, collisions, drops);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/klcat_pkg.sv
rtl/klcat_ram.sv
rtl/kline_collision_aware_transmitter.sv
tb/sv/tb_kline_collision_aware_transmitter.sv
